// File: rtl/core/hds_pkg.sv
// shared constants for the heat diffusion stencil grid
package hds_pkg;
  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_STEP  = 2'd2;
  localparam logic [1:0] CMD_FILL  = 2'd3;
  localparam logic [2:0] REG_WIDTH  = 3'd0;
  localparam logic [2:0] REG_HEIGHT = 3'd1;
  localparam logic [2:0] REG_WX     = 3'd2;
  localparam logic [2:0] REG_WY     = 3'd3;
  localparam logic [2:0] REG_WC     = 3'd4;
  typedef logic signed [31:0] temp_t;
endpackage

// File: rtl/core/heat_diffusion_stencil_grid.sv
// top level of the heat diffusion stencil grid
//
//  channel | signals                           | direction
//  cmd     | cmd_valid cmd_ready cmd x y value | in
//  result  | res_valid res_ready temperature cmd_done | out
//  config  | psel penable pwrite paddr pwdata prdata pready | apb
//
// a write goes straight to S_DONE, an in-grid read via S_RD; a fill writes every used cell
// in S_FILL; a step takes every used cell through S_TAP, S_MAC and S_WB, with one shared
// multiply-accumulate over five taps (one bank read per tap) for an interior cell
// a step or fill on an empty grid goes straight to S_DONE; the step still swaps the banks
// reset clears control state only; the banks hold garbage until written
// the result sits in an output register; a new transaction is taken once it drains
import hds_pkg::*;
module heat_diffusion_stencil_grid #(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cmd_valid,
  output logic        cmd_ready,
  input  logic [1:0]  cmd,
  input  logic [5:0]  x,
  input  logic [5:0]  y,
  input  logic signed [31:0] value,
  output logic        res_valid,
  input  logic        res_ready,
  output logic signed [31:0] temperature,
  output logic [1:0]  cmd_done,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  localparam int XW = $clog2(MAX_WIDTH);
  localparam int YW = $clog2(MAX_HEIGHT);
  localparam int AW = XW + YW;
  localparam int DEPTH = 2 ** AW;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_RD    = 4'd1;
  localparam logic [3:0] S_FILL  = 4'd3;
  localparam logic [3:0] S_TAP   = 4'd4;
  localparam logic [3:0] S_MAC   = 4'd5;
  localparam logic [3:0] S_WB    = 4'd6;
  localparam logic [3:0] S_DONE  = 4'd7;

  // configuration registers
  logic [6:0] grid_width, grid_height;
  logic [15:0] weight_x, weight_y;
  logic signed [18:0] weight_center;

  logic [3:0] state;
  logic [1:0] cur_cmd;
  logic active_bank;
  logic [XW-1:0] cx;
  logic [YW-1:0] cy;
  logic [2:0] tap;
  logic [2:0] mac_tap;
  logic signed [31:0] fill_val;
  logic signed [65:0] acc;
  logic signed [31:0] res_temp;
  logic boundary;

  // used size clamped to the storage
  logic [10:0] uw, uh;
  assign uw = (11'(grid_width) < 11'(MAX_WIDTH)) ? 11'(grid_width) : 11'(MAX_WIDTH);
  assign uh = (11'(grid_height) < 11'(MAX_HEIGHT)) ? 11'(grid_height) : 11'(MAX_HEIGHT);
  logic empty_grid;
  assign empty_grid = (uw == 11'd0) || (uh == 11'd0);

  // apb
  logic apb_wr;
  assign pready = 1'b1;
  assign apb_wr = psel && penable && pwrite;
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width <= 7'd64;
      grid_height <= 7'd64;
      weight_x <= '0;
      weight_y <= '0;
      weight_center <= 19'sd65536;
    end else if (apb_wr) begin
      unique case (paddr[4:2])
        REG_WIDTH:  grid_width <= pwdata[6:0];
        REG_HEIGHT: grid_height <= pwdata[6:0];
        REG_WX:     weight_x <= pwdata[15:0];
        REG_WY:     weight_y <= pwdata[15:0];
        REG_WC:     weight_center <= pwdata[18:0];
        default: ;
      endcase
    end
  end
  always_comb begin
    unique case (paddr[4:2])
      REG_WIDTH:  prdata = {25'd0, grid_width};
      REG_HEIGHT: prdata = {25'd0, grid_height};
      REG_WX:     prdata = {16'd0, weight_x};
      REG_WY:     prdata = {16'd0, weight_y};
      REG_WC:     prdata = {{13{weight_center[18]}}, weight_center};
      default:    prdata = '0;
    endcase
  end

  // bank ports
  logic we_a, we_b;
  logic [AW-1:0] addr_a, addr_b;
  logic [31:0] wd, rd_a, rd_b, rd_act;
  hds_ram #(.Width(32), .Depth(DEPTH)) u_bank_a (
    .clk(clk), .we(we_a), .addr(addr_a), .wdata(wd), .rdata(rd_a));
  hds_ram #(.Width(32), .Depth(DEPTH)) u_bank_b (
    .clk(clk), .we(we_b), .addr(addr_b), .wdata(wd), .rdata(rd_b));
  assign rd_act = active_bank ? rd_b : rd_a;

  // tap address: 0 center, 1 left, 2 right, 3 up, 4 down
  logic [XW-1:0] tx;
  logic [YW-1:0] ty;
  always_comb begin
    tx = cx;
    ty = cy;
    unique case (tap)
      3'd1: tx = cx - 1'b1;
      3'd2: tx = cx + 1'b1;
      3'd3: ty = cy - 1'b1;
      3'd4: ty = cy + 1'b1;
      default: ;
    endcase
  end

  logic in_acc;
  logic in_grid;
  assign cmd_ready = (state == S_IDLE) && !res_valid;
  assign in_acc = cmd_valid && cmd_ready;
  assign in_grid = (11'(x) < uw) && (11'(y) < uh);
  assign boundary = (cx == '0) || (cy == '0) || (11'(cx) + 11'd1 >= uw)
                    || (11'(cy) + 11'd1 >= uh);
  logic last_x, last_y;
  assign last_x = 11'(cx) + 11'd1 >= uw;
  assign last_y = 11'(cy) + 11'd1 >= uh;

  // port drive
  logic [AW-1:0] cur_addr, tap_addr, in_addr;
  assign cur_addr = {cy, cx};
  assign tap_addr = {ty, tx};
  assign in_addr = {YW'(y), XW'(x)};
  logic step_wr;
  assign step_wr = (state == S_WB);
  always_comb begin
    we_a = 1'b0;
    we_b = 1'b0;
    addr_a = tap_addr;
    addr_b = tap_addr;
    wd = res_temp;
    if (in_acc) begin
      addr_a = in_addr;
      addr_b = in_addr;
      wd = value;
      if (cmd == CMD_WRITE && in_grid) begin
        we_a = !active_bank;
        we_b = active_bank;
      end
    end else if (state == S_FILL) begin
      addr_a = cur_addr;
      addr_b = cur_addr;
      wd = fill_val;
      we_a = 1'b1;
      we_b = 1'b1;
    end else if (step_wr) begin
      addr_a = cur_addr;
      addr_b = cur_addr;
      we_a = active_bank;
      we_b = !active_bank;
    end
  end

  // shared multiply: coefficient times one tap
  logic signed [18:0] coef;
  logic signed [51:0] prod;
  always_comb begin
    unique case (mac_tap)
      3'd0: coef = weight_center;
      3'd1, 3'd2: coef = $signed({3'b000, weight_x});
      default: coef = $signed({3'b000, weight_y});
    endcase
  end
  assign prod = 52'(signed'(rd_act)) * 52'(coef);

  // last tap added in, rounded to q16.16 and saturated
  logic signed [65:0] rnd;
  logic signed [49:0] q;
  logic signed [31:0] sat;
  assign rnd = acc + 66'(prod) + 66'sd32768;
  assign q = 50'(rnd >>> 16);
  assign sat = (q > 50'sd2147483647) ? 32'sh7fffffff :
               (q < -50'sd2147483648) ? 32'sh80000000 : q[31:0];

  logic mac_live;
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      res_valid <= 1'b0;
      active_bank <= 1'b0;
      mac_live <= 1'b0;
    end else begin
      if (res_valid && res_ready) res_valid <= 1'b0;
      unique case (state)
        S_IDLE: if (in_acc) begin
          cur_cmd <= cmd;
          res_temp <= '0;
          cx <= '0;
          cy <= '0;
          tap <= '0;
          fill_val <= value;
          unique case (cmd)
            CMD_READ:  begin
              state <= in_grid ? S_RD : S_DONE;
            end
            CMD_FILL:  state <= empty_grid ? S_DONE : S_FILL;
            CMD_STEP:  begin
              // nothing to visit: just swap the banks
              if (empty_grid) begin
                active_bank <= !active_bank;
                state <= S_DONE;
              end else begin
                state <= S_TAP;
              end
            end
            default:   state <= S_DONE;
          endcase
        end
        // read data registered at the accepting edge
        S_RD: begin
          res_temp <= rd_act;
          state <= S_DONE;
        end
        S_FILL: begin
          cx <= last_x ? '0 : cx + 1'b1;
          if (last_x) begin
            cy <= cy + 1'b1;
            if (last_y) state <= S_DONE;
          end
        end
        // issue one tap read per cycle, accumulate it in the cycle after
        S_TAP: begin
          mac_tap <= tap;
          mac_live <= 1'b1;
          if (tap == 3'd0) acc <= '0;
          if (boundary || tap == 3'd4) state <= S_MAC;
          else tap <= tap + 1'b1;
        end
        S_MAC: begin
          if (boundary) begin
            res_temp <= rd_act;
          end
          mac_live <= 1'b0;
          state <= S_WB;
        end
        S_WB: begin
          tap <= '0;
          cx <= last_x ? '0 : cx + 1'b1;
          if (last_x) cy <= cy + 1'b1;
          if (last_x && last_y) begin
            active_bank <= !active_bank;
            state <= S_DONE;
          end else begin
            state <= S_TAP;
          end
        end
        S_DONE: begin
          res_valid <= 1'b1;
          cmd_done <= cur_cmd;
          temperature <= (cur_cmd == CMD_READ) ? res_temp : '0;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
      // accumulate the tap whose read data just arrived
      if (mac_live && !boundary) begin
        if (state == S_MAC) begin
          res_temp <= sat;
        end else begin
          acc <= (mac_tap == 3'd0) ? 66'(prod) : acc + 66'(prod);
        end
      end
    end
  end

  // a result never appears while a command is still busy
  assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (state == S_IDLE || state == S_DONE))
    else $error("result valid while busy");
  // banks swap only at the end of a step, or at once for an empty grid
  assert property (@(posedge clk) disable iff (rst)
    (active_bank != $past(active_bank)) |-> $past(state == S_WB || state == S_IDLE))
    else $error("bank swap outside step");
  // never write both banks except during fill
  assert property (@(posedge clk) disable iff (rst)
    (we_a && we_b) |-> (state == S_FILL))
    else $error("dual bank write");
endmodule

// File: rtl/core/hds_ram.sv
// generic single-port ram with registered read
module hds_ram #(
  parameter int Width = 32,
  parameter int Depth = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

// File: dv/testbench.sv
// self-checking testbench for the heat diffusion stencil grid
import hds_pkg::*;
module testbench;

  localparam int MAX_W       = 64;
  localparam int MAX_H       = 64;
  localparam int CELLS       = MAX_W * MAX_H;
  localparam int STALL_LIMIT = 200000;  // must outlast a full 64x64 step, during which no transaction happens
  localparam int HOLD_CYCLES = 60;

  logic        clk;
  logic        rst;
  logic        cmd_valid;
  logic        cmd_ready;
  logic [1:0]  cmd;
  logic [5:0]  x;
  logic [5:0]  y;
  logic signed [31:0] value;
  logic        res_valid;
  logic        res_ready;
  logic signed [31:0] temperature;
  logic [1:0]  cmd_done;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  heat_diffusion_stencil_grid u_top (.*);

  // clock: period 10
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // expected completion of one command
  typedef struct packed {
    logic [31:0] temp;
    logic [1:0]  op;
  } done_t;

  // one row of the directed table: either a register write or a command
  typedef struct {
    bit          is_cfg;
    logic [2:0]  reg_idx;
    logic [31:0] reg_val;
    logic [1:0]  op;
    logic [5:0]  cx;
    logic [5:0]  cy;
    logic [31:0] val;
    bit          known;     // expected temperature typed in below
    logic [31:0] known_temp;
  } stim_row_t;

  // mirror of the grid and the registers
  logic [31:0] grid_mem [2][CELLS];
  bit          act_bank;
  logic [6:0]  grid_w, grid_h;
  logic [15:0] wt_x, wt_y;
  logic [18:0] wt_c;

  done_t       pending_done[$];
  stim_row_t   directed[$];
  int          errors;
  int          op_count[4];
  int          results_seen;
  int          idle_cycles;
  bit          quiet;     // no idling on either side
  bit          hold_req;  // asks the receiver for a long hold-off

  function automatic int used_w();
    return (grid_w > MAX_W) ? MAX_W : int'(grid_w);
  endfunction

  function automatic int used_h();
    return (grid_h > MAX_H) ? MAX_H : int'(grid_h);
  endfunction

  function automatic longint cell_at(bit b, int idx);
    return longint'($signed(grid_mem[b][idx]));
  endfunction

  // five-point update of one interior cell, rounded and saturated
  function automatic logic [31:0] stencil_cell(bit src, int idx);
    longint acc;
    acc = longint'($signed(wt_c)) * cell_at(src, idx)
        + longint'(wt_x) * (cell_at(src, idx - 1) + cell_at(src, idx + 1))
        + longint'(wt_y) * (cell_at(src, idx - MAX_W) + cell_at(src, idx + MAX_W));
    acc = (acc + 32768) >>> 16;  // floor after adding half an lsb
    if (acc > 64'sd2147483647) acc = 64'sd2147483647;
    if (acc < -64'sd2147483648) acc = -64'sd2147483648;
    return acc[31:0];
  endfunction

  // applies one command to the mirror and returns the expected temperature
  function automatic logic [31:0] grid_command(logic [1:0] op, logic [5:0] cx,
                                               logic [5:0] cy, logic [31:0] val);
    int w, h, idx;
    bit in_grid;
    logic [31:0] temp;
    w = used_w();
    h = used_h();
    in_grid = (int'(cx) < w) && (int'(cy) < h);
    idx = int'(cy) * MAX_W + int'(cx);
    temp = '0;
    case (op)
      CMD_WRITE: begin
        if (in_grid) grid_mem[act_bank][idx] = val;
      end
      CMD_READ: begin
        if (in_grid) temp = grid_mem[act_bank][idx];
      end
      CMD_STEP: begin
        for (int j = 0; j < h; j++)
          for (int i = 0; i < w; i++) begin
            if (i == 0 || j == 0 || i + 1 >= w || j + 1 >= h)
              grid_mem[!act_bank][j * MAX_W + i] = grid_mem[act_bank][j * MAX_W + i];
            else
              grid_mem[!act_bank][j * MAX_W + i] = stencil_cell(act_bank, j * MAX_W + i);
          end
        act_bank = !act_bank;
      end
      default: begin
        for (int j = 0; j < h; j++)
          for (int i = 0; i < w; i++) begin
            grid_mem[0][j * MAX_W + i] = val;
            grid_mem[1][j * MAX_W + i] = val;
          end
      end
    endcase
    return temp;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
    errors++;
  endtask

  // result checker: each transaction against the oldest expectation
  always @(posedge clk) begin
    if (!rst && res_valid && res_ready) begin
      results_seen++;
      if (pending_done.size() == 0) begin
        report_mismatch("result with nothing expected", temperature, '0);
      end else begin
        if (temperature !== pending_done[0].temp)
          report_mismatch("temperature", temperature, pending_done[0].temp);
        if (cmd_done !== pending_done[0].op)
          report_mismatch("cmd_done", 32'(cmd_done), 32'(pending_done[0].op));
        void'(pending_done.pop_front());
      end
    end
  end

  // watchdog: cycles in which no transaction of any kind happens
  always @(posedge clk) begin
    if (rst || (cmd_valid && cmd_ready) || (res_valid && res_ready) || (psel && penable))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("watchdog expired with %0d results outstanding", pending_done.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // receiver: random stalls, a long hold-off on request, none when quiet
  initial begin
    res_ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_req) begin
        res_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        res_ready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
      end else begin
        res_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // register write: setup phase then access phase
  task automatic reg_write(logic [2:0] idx, logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 5'(idx) << 2;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_WIDTH:  grid_w = data[6:0];
      REG_HEIGHT: grid_h = data[6:0];
      REG_WX:     wt_x   = data[15:0];
      REG_WY:     wt_y   = data[15:0];
      default:    wt_c   = data[18:0];
    endcase
  endtask

  // sender pause until every result is back, valid dropped
  task automatic drain();
    cmd_valid <= 1'b0;
    @(posedge clk);
    while (pending_done.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // offers one command, predicts at the accepting edge; valid stays up
  task automatic send_cmd(logic [1:0] op, logic [5:0] cx, logic [5:0] cy,
                          logic [31:0] val, bit known, logic [31:0] known_temp);
    done_t d;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      cmd_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    cmd_valid <= 1'b1;
    cmd   <= op;
    x     <= cx;
    y     <= cy;
    value <= val;
    @(posedge clk);
    while (!cmd_ready) @(posedge clk);
    d.op   = op;
    d.temp = grid_command(op, cx, cy, val);
    if (known) d.temp = known_temp;
    pending_done.push_back(d);
    op_count[op]++;
  endtask

  function automatic stim_row_t cfg_row(logic [2:0] idx, logic [31:0] v);
    stim_row_t r;
    r = '{default: '0};
    r.is_cfg  = 1'b1;
    r.reg_idx = idx;
    r.reg_val = v;
    return r;
  endfunction

  function automatic stim_row_t cmd_row(logic [1:0] op, int cx, int cy, logic [31:0] v,
                                        bit known = 1'b0, logic [31:0] t = '0);
    stim_row_t r;
    r = '{default: '0};
    r.op = op;
    r.cx = 6'(cx);
    r.cy = 6'(cy);
    r.val = v;
    r.known = known;
    r.known_temp = t;
    return r;
  endfunction

  // random coordinate: mostly inside the used grid, sometimes anywhere
  function automatic logic [5:0] pick_coord(int used);
    if (used > 0 && $urandom_range(0, 5) != 0) return 6'($urandom_range(0, used - 1));
    return 6'($urandom_range(0, 63));
  endfunction

  function automatic logic [31:0] pick_temp();
    case ($urandom_range(0, 3))
      0:       return $urandom();
      1:       return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return 32'($signed($urandom_range(0, 20'hFFFFF)) - 20'sh80000) <<< 8;
    endcase
  endfunction

  initial begin
    int w, h, wx;
    logic [1:0] op;
    errors = 0;
    results_seen = 0;
    idle_cycles = 0;
    quiet = 1'b0;
    hold_req = 1'b0;
    act_bank = 1'b0;
    grid_w = 7'd64;
    grid_h = 7'd64;
    wt_x = '0;
    wt_y = '0;
    wt_c = 19'd65536;
    rst       <= 1'b1;
    cmd_valid <= 1'b0;
    cmd       <= CMD_WRITE;
    x         <= '0;
    y         <= '0;
    value     <= '0;
    psel      <= 1'b0;
    penable   <= 1'b0;
    pwrite    <= 1'b0;
    paddr     <= '0;
    pwdata    <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset geometry 64x64, identity weights: fill, extremes, one full step
    directed.push_back(cmd_row(CMD_FILL, 0, 0, 32'h7FFF_FFFF));
    directed.push_back(cmd_row(CMD_READ, 0, 0, 0, 1'b1, 32'h7FFF_FFFF));
    directed.push_back(cmd_row(CMD_READ, 63, 63, 0, 1'b1, 32'h7FFF_FFFF));
    directed.push_back(cmd_row(CMD_WRITE, 63, 0, 32'h8000_0000));
    directed.push_back(cmd_row(CMD_READ, 63, 0, 0, 1'b1, 32'h8000_0000));
    directed.push_back(cmd_row(CMD_STEP, 0, 0, 0));
    directed.push_back(cmd_row(CMD_READ, 63, 0, 0, 1'b1, 32'h8000_0000));
    directed.push_back(cmd_row(CMD_READ, 1, 1, 0, 1'b1, 32'h7FFF_FFFF));
    // 5x4 with extreme weights: saturation both ways, outside cells
    directed.push_back(cfg_row(REG_WIDTH, 5));
    directed.push_back(cfg_row(REG_HEIGHT, 4));
    directed.push_back(cfg_row(REG_WX, 32'hFFFF));
    directed.push_back(cfg_row(REG_WY, 32'hFFFF));
    directed.push_back(cfg_row(REG_WC, 32'hFFFC_0000));  // most negative center weight
    directed.push_back(cmd_row(CMD_FILL, 0, 0, 32'h7FFF_FFFF));
    directed.push_back(cmd_row(CMD_WRITE, 2, 1, 32'h8000_0000));
    directed.push_back(cmd_row(CMD_READ, 40, 2, 0, 1'b1, 32'h0));
    directed.push_back(cmd_row(CMD_WRITE, 40, 2, 32'h5));
    directed.push_back(cmd_row(CMD_STEP, 0, 0, 0));
    directed.push_back(cmd_row(CMD_READ, 1, 1, 0));
    directed.push_back(cmd_row(CMD_READ, 2, 1, 0));
    directed.push_back(cmd_row(CMD_READ, 4, 3, 0, 1'b1, 32'h7FFF_FFFF));
    // most positive center weight
    directed.push_back(cfg_row(REG_WC, 32'h3FFFF));
    directed.push_back(cmd_row(CMD_STEP, 0, 0, 0));
    directed.push_back(cmd_row(CMD_READ, 2, 2, 0));
    // grid too narrow for interior cells, height beyond the maximum
    directed.push_back(cfg_row(REG_WIDTH, 2));
    directed.push_back(cfg_row(REG_HEIGHT, 100));
    directed.push_back(cmd_row(CMD_FILL, 0, 0, 32'hFFFF_FFFF));
    directed.push_back(cmd_row(CMD_WRITE, 1, 63, 32'h1234_5678));
    directed.push_back(cmd_row(CMD_STEP, 0, 0, 0));
    directed.push_back(cmd_row(CMD_READ, 1, 63, 0, 1'b1, 32'h1234_5678));
    // empty grid
    directed.push_back(cfg_row(REG_WIDTH, 0));
    directed.push_back(cmd_row(CMD_READ, 0, 0, 0, 1'b1, 32'h0));
    directed.push_back(cmd_row(CMD_STEP, 0, 0, 0));

    foreach (directed[i]) begin
      if (directed[i].is_cfg) begin
        drain();
        reg_write(directed[i].reg_idx, directed[i].reg_val);
      end else begin
        send_cmd(directed[i].op, directed[i].cx, directed[i].cy, directed[i].val,
                 directed[i].known, directed[i].known_temp);
      end
    end

    // random phases: new geometry and weights, a fill, then mixed commands
    for (int ph = 0; ph < 7; ph++) begin
      drain();
      case (ph)
        3:       begin w = 64; h = 3; end
        4:       begin w = 3; h = 64; end
        default: begin w = $urandom_range(3, 10); h = $urandom_range(3, 10); end
      endcase
      if ($urandom_range(0, 1)) begin
        wx = $urandom_range(0, 16000);
        reg_write(REG_WX, wx);
        reg_write(REG_WY, wx);
        reg_write(REG_WC, 32'(65536 - 4 * wx));
      end else begin
        reg_write(REG_WX, $urandom_range(0, 65535));
        reg_write(REG_WY, $urandom_range(0, 65535));
        reg_write(REG_WC, $urandom());
      end
      reg_write(REG_WIDTH, w);
      reg_write(REG_HEIGHT, h);
      if (ph == 6) quiet = 1'b1;
      send_cmd(CMD_FILL, pick_coord(0), pick_coord(0), pick_temp(), 1'b0, '0);
      for (int k = 0; k < 16; k++) begin
        if (ph == 1 && k == 2) hold_req = 1'b1;  // receiver backs up while we keep sending
        if (ph == 2 && k == 10) drain();
        case ($urandom_range(0, 19))
          0, 1, 2:    op = CMD_STEP;
          3:          op = CMD_FILL;
          4, 5, 6, 7,
          8, 9, 10:   op = CMD_WRITE;
          default:    op = CMD_READ;
        endcase
        send_cmd(op, pick_coord(used_w()), pick_coord(used_h()), pick_temp(), 1'b0, '0);
      end
    end

    drain();
    repeat (20) @(posedge clk);
    $display("covered %0d writes, %0d reads, %0d steps, %0d fills; %0d results checked",
             op_count[CMD_WRITE], op_count[CMD_READ], op_count[CMD_STEP],
             op_count[CMD_FILL], results_seen);
    if (errors == 0 && pending_done.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches, %0d results outstanding", errors, pending_done.size());
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/core/hds_pkg.sv
rtl/core/hds_ram.sv
rtl/core/heat_diffusion_stencil_grid.sv
dv/testbench.sv
